// File: design/hvn3_pkg.sv
// Shared constants and helper functions for the hashed 3D value noise core.
`timescale 1ns / 1ps
`default_nettype none

package hvn3_pkg;

	localparam int COORD_W       = 32;
	localparam int VALUE_W       = 16;
	localparam int HASH_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CORNERS       = 8;
	// Register stages from the input to the output register.
	localparam int PIPE_DEPTH    = 10;

	localparam logic [HASH_W-1:0] HASH_X   = 32'd374761393;
	localparam logic [HASH_W-1:0] HASH_Y   = 32'd668265263;
	localparam logic [HASH_W-1:0] HASH_Z   = 32'd2246822519;
	localparam logic [HASH_W-1:0] HASH_MIX = 32'd1274126177;

	// First xor-shift of the corner hash, applied before the mixing multiply.
	function automatic logic [HASH_W-1:0] hash_fold13(input logic [HASH_W-1:0] h);
		return h ^ (h >> 13);
	endfunction

	// Final xor-shift; the low bits are the corner value.
	function automatic logic [VALUE_W-1:0] hash_final(input logic [HASH_W-1:0] h);
		logic [HASH_W-1:0] t;
		t = h ^ (h >> 16);
		return t[VALUE_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: design/hvn3_hash.sv
// Corner hash lane: eight lattice corner hashes in four register stages.
`timescale 1ns / 1ps
`default_nettype none

module hvn3_hash (
	input  logic                                                    clk,
	input  logic                                                    en,
	input  logic [hvn3_pkg::COORD_W-1:0]                            cell_x,
	input  logic [hvn3_pkg::COORD_W-1:0]                            cell_y,
	input  logic [hvn3_pkg::COORD_W-1:0]                            cell_z,
	output logic [hvn3_pkg::CORNERS-1:0][hvn3_pkg::HASH_W-1:0]      hash_s4
);
	import hvn3_pkg::*;

	logic [HASH_W-1:0]               hx_s1, hy_s1, hz_s1;
	logic [HASH_W-1:0]               hx1, hy1;
	logic [3:0][HASH_W-1:0]          hxy_d;
	logic [3:0][HASH_W-1:0]          hxy_s2;
	logic [1:0][HASH_W-1:0]          hz_s2;
	logic [CORNERS-1:0][HASH_W-1:0]  mix_s3;

	// The hash is linear in each coordinate, so the upper corner of an axis is
	// the lower corner's product plus the constant.
	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1 <= HASH_W'(cell_x * HASH_X);
			hy_s1 <= HASH_W'(cell_y * HASH_Y);
			hz_s1 <= HASH_W'(cell_z * HASH_Z);
		end
	end

	always_comb begin
		hx1      = hx_s1 + HASH_X;
		hy1      = hy_s1 + HASH_Y;
		hxy_d[0] = hx_s1 + hy_s1;
		hxy_d[1] = hx1 + hy_s1;
		hxy_d[2] = hx_s1 + hy1;
		hxy_d[3] = hx1 + hy1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hxy_s2   <= hxy_d;
			hz_s2[0] <= hz_s1;
			hz_s2[1] <= hz_s1 + HASH_Z;
		end
	end

	// Corner index bits are {dz, dy, dx}.
	for (genvar c = 0; c < CORNERS; c++) begin : g_corner
		localparam logic [2:0] CI = 3'(c);

		always_ff @(posedge clk) begin
			if (en) begin
				mix_s3[c]  <= hash_fold13(hxy_s2[CI[1:0]] + hz_s2[CI[2]]);
				hash_s4[c] <= HASH_W'(mix_s3[c] * HASH_MIX);
			end
		end
	end

endmodule

`default_nettype wire

// File: design/hvn3_smooth.sv
// Smoothstep lane: blend weights for the three axes in four register stages.
`timescale 1ns / 1ps
`default_nettype none

module hvn3_smooth #(
	parameter int FRAC_BITS = hvn3_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic [2:0][FRAC_BITS-1:0]          frac,
	output logic [2:0][1:0][FRAC_BITS:0]       weight_s4
);
	import hvn3_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int SQ_W  = 2 * F;
	localparam int K_W   = F + 2;
	localparam int P_W   = 2 * F + 2;
	localparam int SUM_W = 2 * F + 3;
	localparam int W_W   = F + 1;

	localparam logic [K_W-1:0] THREE_ONE = K_W'(3) << F;
	localparam logic [W_W-1:0] ONE       = W_W'(1) << F;

	logic [2:0][SQ_W-1:0]         sq_s1;
	logic [2:0][K_W-1:0]          k_s1;
	logic [2:0][P_W-1:0]          ph_s2, pl_s2;
	logic [2:0][SUM_W-1:0]        sum_d;
	logic [2:0][F-1:0]            s_d;
	logic [2:0][1:0][W_W-1:0]     weight_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				sq_s1[a] <= SQ_W'(frac[a]) * SQ_W'(frac[a]);
				k_s1[a]  <= THREE_ONE - K_W'({frac[a], 1'b0});
			end
		end
	end

	// The square is split in halves so each product stays near F by F bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				ph_s2[a] <= P_W'(sq_s1[a][SQ_W-1:F]) * P_W'(k_s1[a]);
				pl_s2[a] <= P_W'(sq_s1[a][F-1:0]) * P_W'(k_s1[a]);
			end
		end
	end

	// The smoothstep of a fraction below one is itself below one.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_d[a] = SUM_W'(ph_s2[a]) + SUM_W'(pl_s2[a][P_W-1:F]);
			s_d[a]   = sum_d[a][F +: F];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				weight_s3[a][0] <= ONE - W_W'(s_d[a]);
				weight_s3[a][1] <= W_W'(s_d[a]);
			end
			weight_s4 <= weight_s3;
		end
	end

endmodule

`default_nettype wire

// File: design/hvn3_blend.sv
// Trilinear blend of the eight corner values, stages five through ten.
`timescale 1ns / 1ps
`default_nettype none

module hvn3_blend #(
	parameter int FRAC_BITS = hvn3_pkg::FRAC_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 en,
	input  logic [hvn3_pkg::CORNERS-1:0][hvn3_pkg::HASH_W-1:0]   hash_s4,
	input  logic [2:0][1:0][FRAC_BITS:0]                         weight_s4,
	output logic [hvn3_pkg::VALUE_W-1:0]                         noise_s10
);
	import hvn3_pkg::*;

	localparam int F     = FRAC_BITS;
	localparam int W_W   = F + 1;
	localparam int XP_W  = VALUE_W + F;
	localparam int YP_W  = VALUE_W + 2 * F;
	localparam int ZH_W  = VALUE_W + 2 * F;
	localparam int ZL_W  = 2 * F;
	localparam int ZS_W  = 2 * F + 1;
	localparam int FIN_W = VALUE_W + 2 * F + 1;

	logic [CORNERS-1:0][XP_W-1:0]   xp_s5;
	logic [1:0][1:0][W_W-1:0]       wyz_s5, wyz_s6;
	logic [3:0][XP_W-1:0]           row_s6;
	logic [3:0][YP_W-1:0]           yp_s7;
	logic [1:0][W_W-1:0]            wz_s7, wz_s8;
	logic [1:0][YP_W-1:0]           plane_s8;
	logic [1:0][ZH_W-1:0]           zh_s9;
	logic [1:0][ZL_W-1:0]           zl_s9;
	logic [ZS_W-1:0]                zl_sum;
	logic [FIN_W-1:0]               fin_d;

	// Blend along x: one product per corner, weight chosen by the dx bit.
	for (genvar c = 0; c < CORNERS; c++) begin : g_x
		localparam logic [2:0] CI = 3'(c);

		always_ff @(posedge clk) begin
			if (en) begin
				xp_s5[c] <= XP_W'(hash_final(hash_s4[c])) * XP_W'(weight_s4[0][CI[0]]);
			end
		end
	end

	// Rows are indexed {dz, dy}; each sums the two corners that differ in dx.
	for (genvar r = 0; r < 4; r++) begin : g_y
		localparam logic [1:0] RI = 2'(r);

		always_ff @(posedge clk) begin
			if (en) begin
				row_s6[r] <= xp_s5[2 * r] + xp_s5[2 * r + 1];
				yp_s7[r]  <= YP_W'(row_s6[r]) * YP_W'(wyz_s6[0][RI[0]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wyz_s5[0] <= weight_s4[1];
			wyz_s5[1] <= weight_s4[2];
			wyz_s6    <= wyz_s5;
			wz_s7     <= wyz_s6[1];
			wz_s8     <= wz_s7;
			for (int p = 0; p < 2; p++) begin
				plane_s8[p] <= yp_s7[2 * p] + yp_s7[2 * p + 1];
				zh_s9[p]    <= ZH_W'(plane_s8[p][YP_W-1:F]) * ZH_W'(wz_s8[p]);
				zl_s9[p]    <= ZL_W'(plane_s8[p][F-1:0]) * ZL_W'(wz_s8[p]);
			end
		end
	end

	// The blend along z is split into high and low parts of each plane; the
	// weights sum to one, so the truncated sum always fits in sixteen bits.
	always_comb begin
		zl_sum = ZS_W'(zl_s9[0]) + ZS_W'(zl_s9[1]);
		fin_d  = FIN_W'(zh_s9[0]) + FIN_W'(zh_s9[1]) + FIN_W'(zl_sum >> F);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			noise_s10 <= fin_d[2 * F +: VALUE_W];
		end
	end

endmodule

`default_nettype wire

// File: design/hashed_value_noise_3d_core.sv
// Top level of the hashed 3D value noise core.
`timescale 1ns / 1ps
`default_nettype none

// Takes one point per clock in signed fixed point with FRAC_BITS fraction bits
// and returns its trilinearly blended, smoothstepped value noise in Q0.16. The
// pipeline is ten register stages deep; when the output is not held, the
// sustained rate is one item per cycle. The corner hash multiplies and the
// three blend multiplies set the depth. When a result waits at the output,
// the whole pipeline holds and in_ready drops in the same cycle; nothing is
// lost or repeated.
module hashed_value_noise_3d_core #(
	parameter int FRAC_BITS = hvn3_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [hvn3_pkg::COORD_W-1:0]   coord_x,
	input  logic signed [hvn3_pkg::COORD_W-1:0]   coord_y,
	input  logic signed [hvn3_pkg::COORD_W-1:0]   coord_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [hvn3_pkg::VALUE_W-1:0]          noise_value
);
	import hvn3_pkg::*;

	logic [PIPE_DEPTH-1:0]            vld_q;
	logic                             en;
	logic [COORD_W-1:0]               cell_x, cell_y, cell_z;
	logic [2:0][FRAC_BITS-1:0]        frac;
	logic [CORNERS-1:0][HASH_W-1:0]   hash_s4;
	logic [2:0][1:0][FRAC_BITS:0]     weight_s4;

	assign en        = !vld_q[PIPE_DEPTH-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[PIPE_DEPTH-1];

	// Floor of a fixed-point coordinate is an arithmetic shift.
	assign cell_x  = COORD_W'(coord_x >>> FRAC_BITS);
	assign cell_y  = COORD_W'(coord_y >>> FRAC_BITS);
	assign cell_z  = COORD_W'(coord_z >>> FRAC_BITS);
	assign frac[0] = coord_x[FRAC_BITS-1:0];
	assign frac[1] = coord_y[FRAC_BITS-1:0];
	assign frac[2] = coord_z[FRAC_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	hvn3_hash u_hash (
		.clk     (clk),
		.en      (en),
		.cell_x  (cell_x),
		.cell_y  (cell_y),
		.cell_z  (cell_z),
		.hash_s4 (hash_s4)
	);

	hvn3_smooth #(
		.FRAC_BITS (FRAC_BITS)
	) u_smooth (
		.clk       (clk),
		.en        (en),
		.frac      (frac),
		.weight_s4 (weight_s4)
	);

	hvn3_blend #(
		.FRAC_BITS (FRAC_BITS)
	) u_blend (
		.clk       (clk),
		.en        (en),
		.hash_s4   (hash_s4),
		.weight_s4 (weight_s4),
		.noise_s10 (noise_value)
	);

endmodule

`default_nettype wire

// File: design/hvn3_checker.sv
// Port-level checks of the noise core's flow control, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hvn3_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [hvn3_pkg::VALUE_W-1:0]  noise_value
);

	// A result that is not taken stays on the output unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(noise_value))
		else $error("result changed or vanished while held");

	// The input side is only held back by a waiting result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without back-pressure");

	// Taking a result always frees the input side in the same cycle.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("in_ready low while a result is taken");

endmodule

bind hashed_value_noise_3d_core hvn3_checker u_hvn3_checker (.*);

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the hashed 3D value noise core.
`timescale 1ns / 1ps
`default_nettype none

// Expected noise values, kept in the order that their points were accepted.
class noise_scoreboard;
	localparam int F = hvn3_pkg::FRAC_BITS_DEF;
	typedef logic [127:0] wide_t;

	logic [hvn3_pkg::VALUE_W-1:0] expected_values[$];
	int points_noted;
	int values_checked;
	int mismatches;

	function new();
		points_noted = 0;
		values_checked = 0;
		mismatches = 0;
	endfunction

	function automatic logic [hvn3_pkg::VALUE_W-1:0] lattice_hash(
		input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
		logic [31:0] h;
		h = a * hvn3_pkg::HASH_X + b * hvn3_pkg::HASH_Y + c * hvn3_pkg::HASH_Z;
		h = (h ^ (h >> 13)) * hvn3_pkg::HASH_MIX;
		h = h ^ (h >> 16);
		return h[hvn3_pkg::VALUE_W-1:0];
	endfunction

	// Cubic ease curve of the fraction, truncated to F bits.
	function automatic wide_t ease(input logic [31:0] word);
		wide_t f;
		wide_t one;
		one = wide_t'(1) << F;
		f = wide_t'(word[F-1:0]);
		return (f * f * (3 * one - 2 * f)) >> (2 * F);
	endfunction

	// All eight corner products are summed exactly, then truncated once.
	function automatic logic [hvn3_pkg::VALUE_W-1:0] noise_of(
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z);
		logic [31:0] lx, ly, lz;
		wide_t sx, sy, sz, wx, wy, wz, one, acc;
		int dx, dy, dz;
		lx = x >>> F;
		ly = y >>> F;
		lz = z >>> F;
		sx = ease(x);
		sy = ease(y);
		sz = ease(z);
		one = wide_t'(1) << F;
		acc = '0;
		for (dz = 0; dz < 2; dz++) begin
			wz = dz ? sz : one - sz;
			for (dy = 0; dy < 2; dy++) begin
				wy = dy ? sy : one - sy;
				for (dx = 0; dx < 2; dx++) begin
					wx = dx ? sx : one - sx;
					acc += wide_t'(lattice_hash(lx + 32'(dx), ly + 32'(dy), lz + 32'(dz)))
						* wx * wy * wz;
				end
			end
		end
		acc = acc >> (3 * F);
		return acc[hvn3_pkg::VALUE_W-1:0];
	endfunction

	function void note_point(input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z);
		expected_values.push_back(noise_of(x, y, z));
		points_noted++;
	endfunction

	function void check_value(input logic [hvn3_pkg::VALUE_W-1:0] actual);
		logic [hvn3_pkg::VALUE_W-1:0] want;
		if (expected_values.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: noise value %0d arrived with nothing expected", actual);
			return;
		end
		want = expected_values.pop_front();
		values_checked++;
		if (actual !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("ERROR: noise value %0d: expected %0d, got %0d",
					values_checked - 1, want, actual);
		end
	endfunction

	function int pending();
		return expected_values.size();
	endfunction
endclass

module tb_top;
	localparam int F = hvn3_pkg::FRAC_BITS_DEF;
	localparam int RANDOM_POINTS = 800;
	localparam int CYCLE_LIMIT = 500000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [hvn3_pkg::COORD_W-1:0] coord_x;
	logic signed [hvn3_pkg::COORD_W-1:0] coord_y;
	logic signed [hvn3_pkg::COORD_W-1:0] coord_z;
	logic out_valid;
	logic out_ready;
	logic [hvn3_pkg::VALUE_W-1:0] noise_value;

	noise_scoreboard sb;
	bit calm;
	int cycles;

	hashed_value_noise_3d_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.noise_value(noise_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
	end

	// Mostly no gap or a short one, now and then a long one.
	function automatic int rand_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Random coordinate, weighted toward small cells, lattice points and word extremes.
	function automatic logic [31:0] rand_coord();
		logic [31:0] w;
		logic [15:0] fr;
		w = $urandom;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: ;
			4, 5: w = $urandom_range(0, 16 << F) - (8 << F);
			6: w = {w[31:16], 16'h0000};
			7: begin
				case ($urandom_range(0, 3))
					0: fr = 16'h0000;
					1: fr = 16'hffff;
					2: fr = 16'h0001;
					default: fr = 16'h8000;
				endcase
				w = {w[31:16], fr};
			end
			8: w = {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, w[15:0]};
			default: w = {16'hffff, w[15:0]};
		endcase
		return w;
	endfunction

	task automatic send_point(input int gap, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Both handshakes are observed here, with the values seen by the flops.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_point(coord_x, coord_y, coord_z);
			if (out_valid && out_ready)
				sb.check_value(noise_value);
		end
	end

	// Result side: random stalls of the same shape as the input gaps.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = rand_gap();
			if (n > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
			@(negedge clk);
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 7)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial cycles = 0;

	initial begin
		int i;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed corners of the input space.
		send_point(0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		send_point(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		send_point(1, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
		send_point(0, 32'h7fff_0000, 32'h8000_ffff, 32'h0000_ffff);
		// Lattice points must return the bare corner value.
		send_point(0, 32'h0005_0000, 32'hfffd_0000, 32'h0000_0000);
		send_point(0, 32'h7fff_0000, 32'h8000_0000, 32'hffff_0000);
		send_point(2, 32'h1234_0000, 32'h0001_0000, 32'hffff_0000);
		// Fractions at their ends and at the midpoint.
		send_point(0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
		send_point(0, 32'h0000_ffff, 32'h0000_ffff, 32'h0000_ffff);
		send_point(0, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
		send_point(0, 32'hffff_8000, 32'h0003_4000, 32'hfffe_c000);
		send_point(0, 32'h5555_5555, 32'haaaa_aaaa, 32'h3c3c_c3c3);
		send_point(0, 32'haaaa_aaaa, 32'h5555_5555, 32'hc3c3_3c3c);
		send_point(3, 32'h0001_0000, 32'h0000_8000, 32'h0000_ffff);
		drain();

		for (i = 0; i < RANDOM_POINTS; i++) begin
			calm = (i >= 200 && i < 300);
			if (i == 400)
				drain();
			send_point(rand_gap(), rand_coord(), rand_coord(), rand_coord());
		end
		calm = 1'b0;

		drain();
		repeat (hvn3_pkg::PIPE_DEPTH + 10) @(posedge clk);
		$display("Sent %0d points and checked %0d noise values, under random gaps and stalls",
			sb.points_noted, sb.values_checked);
		$display("on both sides, covering word extremes, lattice points and edge fractions.");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

`default_nettype wire
